// ===== design/wildcard_byte_pattern_scanner_assert.svh =====
// assertion helpers for the byte pattern scanner
// both expect signals named clk and rst in the including module
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define WBPS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define WBPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/wbps_pkg.sv =====
`default_nettype none

package wbps_pkg;

  // configuration port geometry
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_0 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_1 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_2 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_3 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_WILDCARD_MASK  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd5;

  // field widths
  localparam int MASK_W           = 32;
  localparam int PATTERN_LENGTH_W = 6;
  localparam int MATCH_OFFSET_W   = 32;
  localparam int WORD_BYTES_LOG2  = 3;

  // hard ceiling on pattern positions
  localparam int LEN_LIMIT = 32;

endpackage

`default_nettype wire

// ===== design/wbps_cfg.sv =====
`default_nettype none

module wbps_cfg #(
  parameter  int LEN_CAP = 32,
  localparam int LEN_W   = $clog2(LEN_CAP + 1)
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [wbps_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [wbps_pkg::CFG_DATA_W-1:0]     cfg_data,
  output      logic [LEN_CAP-1:0][7:0]             apat,
  output      logic [LEN_CAP-1:0]                  amask,
  output      logic [LEN_W-1:0]                    eff_len
);

  logic [LEN_CAP-1:0][7:0]                   pat;
  logic [LEN_CAP-1:0]                        wmask;
  logic [wbps_pkg::PATTERN_LENGTH_W-1:0]     plen;

  logic [LEN_W-1:0]                          eff_len_next;
  logic [LEN_W-1:0]                          shift;
  logic [LEN_CAP-1:0][7:0]                   rev_pat;
  logic [LEN_CAP-1:0]                        rev_mask;
  logic [LEN_CAP-1:0]                        used;
  logic [LEN_CAP-1:0][7:0]                   apat_next;
  logic [LEN_CAP-1:0]                        amask_next;

  // register writes, pattern words split into bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      pat   <= '0;
      wmask <= '0;
      plen  <= wbps_pkg::PATTERN_LENGTH_W'(1);
    end else if (cfg_we) begin
      for (int k = 0; k < LEN_CAP; k++) begin
        if (cfg_index == wbps_pkg::REG_PATTERN_WORD_0
                         + wbps_pkg::CFG_INDEX_W'(k >> wbps_pkg::WORD_BYTES_LOG2)) begin
          pat[k] <= cfg_data[8 * (k & 7) +: 8];
        end
      end
      if (cfg_index == wbps_pkg::REG_WILDCARD_MASK) begin
        wmask <= cfg_data[LEN_CAP-1:0];
      end
      if (cfg_index == wbps_pkg::REG_PATTERN_LENGTH) begin
        plen <= cfg_data[wbps_pkg::PATTERN_LENGTH_W-1:0];
      end
    end
  end

  // clamp length to 1..LEN_CAP
  always_comb begin
    if (plen == '0) begin
      eff_len_next = LEN_W'(1);
    end else if (plen > wbps_pkg::PATTERN_LENGTH_W'(LEN_CAP)) begin
      eff_len_next = LEN_W'(LEN_CAP);
    end else begin
      eff_len_next = LEN_W'(plen);
    end
  end

  // reverse pattern order so slot 0 lines up with the newest byte
  always_comb begin
    for (int k = 0; k < LEN_CAP; k++) begin
      rev_pat[k]  = pat[LEN_CAP-1-k];
      rev_mask[k] = wmask[LEN_CAP-1-k];
    end
  end

  // slot j of the window compares against pattern byte eff_len-1-j
  assign shift      = LEN_W'(LEN_CAP) - eff_len_next;
  assign apat_next  = rev_pat >> {shift, 3'b000};
  assign used       = {LEN_CAP{1'b1}} >> shift;
  assign amask_next = (rev_mask >> shift) | ~used;

  // aligned copy, refreshed every cycle
  always_ff @(posedge clk) begin
    apat    <= apat_next;
    amask   <= amask_next;
    eff_len <= eff_len_next;
  end

endmodule

`default_nettype wire

// ===== design/wildcard_byte_pattern_scanner.sv =====
// channel  | handshake                 | payload
// ---------+---------------------------+--------------------------------
// in       | in_valid / in_stall       | data_byte, region_end
// out      | out_valid / out_stall     | found, match_offset
// cfg      | cfg_we (no wait)          | cfg_index, cfg_data
//
// one item per cycle sustained while the output is not stalled; an item is
// registered in the window stage, then its result enters the output register.
// rst is synchronous and clears pattern config and scan state.
// in_stall rises only when the window stage is full and the output
// register holds a result that is stalled.
`default_nettype none

`include "wildcard_byte_pattern_scanner_assert.svh"

module wildcard_byte_pattern_scanner #(
  parameter int MAX_PATTERN_BYTES = 32,
  parameter int OFFSET_BITS       = 32
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     cfg_we,
  input  wire logic [wbps_pkg::CFG_INDEX_W-1:0]         cfg_index,
  input  wire logic [wbps_pkg::CFG_DATA_W-1:0]          cfg_data,
  input  wire logic                                     in_valid,
  output      logic                                     in_stall,
  input  wire logic [7:0]                               data_byte,
  input  wire logic                                     region_end,
  output      logic                                     out_valid,
  input  wire logic                                     out_stall,
  output      logic                                     found,
  output      logic [wbps_pkg::MATCH_OFFSET_W-1:0]      match_offset
);

  localparam int LEN_CAP = (MAX_PATTERN_BYTES < wbps_pkg::LEN_LIMIT)
                           ? MAX_PATTERN_BYTES : wbps_pkg::LEN_LIMIT;
  localparam int LEN_W   = $clog2(LEN_CAP + 1);
  localparam int OFS_W   = wbps_pkg::MATCH_OFFSET_W;

  logic [LEN_CAP-1:0][7:0]  apat;
  logic [LEN_CAP-1:0]       amask;
  logic [LEN_W-1:0]         eff_len;

  // window stage
  logic [LEN_CAP-1:0][7:0]  win;
  logic                     s1_valid;
  logic                     s1_last;
  logic [OFFSET_BITS-1:0]   bytes_seen;
  logic [OFFSET_BITS-1:0]   count_base;

  // result stage
  logic                     already_found;
  logic [LEN_CAP-1:0]       byte_ok;
  logic                     win_match;
  logic                     count_ok;
  logic                     hit;
  logic                     emit;
  logic [OFFSET_BITS-1:0]   diff;

  logic                     out_free;
  logic                     s1_advance;
  logic                     in_accept;

  wbps_cfg #(
    .LEN_CAP (LEN_CAP)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .apat      (apat),
    .amask     (amask),
    .eff_len   (eff_len)
  );

  // flow control
  assign out_free   = !out_valid || !out_stall;
  assign s1_advance = s1_valid && out_free;
  assign in_stall   = s1_valid && !out_free;
  assign in_accept  = in_valid && !in_stall;

  // count restarts after the last byte of a region
  assign count_base = s1_last ? '0 : bytes_seen;

  // window shift and byte count
  always_ff @(posedge clk) begin
    if (in_accept) begin
      win <= {win[LEN_CAP-2:0], data_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s1_last    <= 1'b0;
      bytes_seen <= '0;
    end else begin
      if (in_accept) begin
        s1_valid   <= 1'b1;
        s1_last    <= region_end;
        bytes_seen <= (count_base == '1) ? count_base
                                         : count_base + OFFSET_BITS'(1);
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // masked compare of every window slot
  always_comb begin
    for (int j = 0; j < LEN_CAP; j++) begin
      byte_ok[j] = amask[j] || (win[j] == apat[j]);
    end
  end

  assign win_match = &byte_ok;
  assign count_ok  = bytes_seen >= OFFSET_BITS'(eff_len);
  assign hit       = !already_found && count_ok && win_match;
  assign emit      = hit || (s1_last && !already_found);
  assign diff      = bytes_seen - OFFSET_BITS'(eff_len);

  // first-match flag, cleared at region end
  always_ff @(posedge clk) begin
    if (rst) begin
      already_found <= 1'b0;
    end else if (s1_advance) begin
      if (s1_last) begin
        already_found <= 1'b0;
      end else if (hit) begin
        already_found <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && emit) begin
      found        <= hit;
      match_offset <= hit ? OFS_W'(diff) : '0;
    end
  end

  // checks
  `WBPS_ASSERT_SAME(a_stall_cause, in_stall, s1_valid && out_valid && out_stall, "input stalled without a blocked result")
  `WBPS_ASSERT_SAME(a_count_live, s1_valid, bytes_seen != '0, "item in window stage with zero byte count")
  `WBPS_ASSERT_SAME(a_miss_offset, out_valid && !found, match_offset == '0, "not-found item carries an offset")
  `WBPS_ASSERT_NEXT(a_flag_track, s1_advance && hit, already_found != $past(s1_last), "match flag not updated after a hit")

endmodule

`default_nettype wire

// ===== dv/wbps_scan_checker.sv =====
module wbps_scan_checker
  import wbps_pkg::*;
#(
  parameter int WINDOW_BYTES = 32,
  parameter int OFFSET_W     = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [7:0]                data_byte,
  input  logic                      region_end,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic                      found,
  input  logic [MATCH_OFFSET_W-1:0] match_offset,
  output int                        mismatches,
  output int                        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEN_CAP = (WINDOW_BYTES < LEN_LIMIT) ? WINDOW_BYTES : LEN_LIMIT;

  typedef struct packed {
    logic                      found;
    logic [MATCH_OFFSET_W-1:0] offset;
  } scan_result_t;

  // register copy
  logic [CFG_DATA_W-1:0]       pattern_words [4];
  logic [MASK_W-1:0]           any_byte_mask;
  logic [PATTERN_LENGTH_W-1:0] length_reg;

  // per-region scan state
  logic [7:0]          history [WINDOW_BYTES];
  logic [OFFSET_W-1:0] bytes_in_region;
  logic                region_hit;

  scan_result_t expected_hits [$];
  int           bad_count = 0;
  int           waiting   = 0;

  assign mismatches = bad_count;
  assign pending    = waiting;

  function automatic void clear_region();
    foreach (history[i]) history[i] = 8'h00;
    bytes_in_region = '0;
    region_hit      = 1'b0;
  endfunction

  // shift one byte into the window and queue whatever result it causes
  function automatic void scan_byte(input logic [7:0] value, input logic last);
    int unsigned  len;
    int unsigned  i;
    logic         same;
    scan_result_t res;
    len = (length_reg == '0) ? 1 : length_reg;
    if (len > LEN_CAP) len = LEN_CAP;
    for (i = WINDOW_BYTES - 1; i > 0; i--) history[i] = history[i - 1];
    history[0] = value;
    if (bytes_in_region != '1) bytes_in_region++;
    // oldest byte of the window lines up with pattern position 0
    if (!region_hit && bytes_in_region >= len) begin
      same = 1'b1;
      for (i = 0; i < len; i++) begin
        if (!any_byte_mask[i] &&
            history[len - 1 - i] != pattern_words[i / 8][(i % 8) * 8 +: 8]) begin
          same = 1'b0;
        end
      end
      if (same) begin
        region_hit = 1'b1;
        res.found  = 1'b1;
        res.offset = MATCH_OFFSET_W'(bytes_in_region - len);
        expected_hits.push_back(res);
      end
    end
    // region closes: report a miss unless a hit already went out
    if (last) begin
      if (!region_hit) begin
        res.found  = 1'b0;
        res.offset = '0;
        expected_hits.push_back(res);
      end
      clear_region();
    end
  endfunction

  always @(posedge clk) begin
    scan_result_t want;
    if (rst) begin
      foreach (pattern_words[i]) pattern_words[i] = '0;
      any_byte_mask = '0;
      length_reg    = PATTERN_LENGTH_W'(1);
      clear_region();
      expected_hits.delete();
    end else begin
      // register writes, unknown indexes dropped
      if (cfg_we) begin
        case (cfg_index)
          REG_PATTERN_WORD_0: pattern_words[0] = cfg_data;
          REG_PATTERN_WORD_1: pattern_words[1] = cfg_data;
          REG_PATTERN_WORD_2: pattern_words[2] = cfg_data;
          REG_PATTERN_WORD_3: pattern_words[3] = cfg_data;
          REG_WILDCARD_MASK:  any_byte_mask = cfg_data[MASK_W-1:0];
          REG_PATTERN_LENGTH: length_reg = cfg_data[PATTERN_LENGTH_W-1:0];
          default: ;
        endcase
      end
      // compare an accepted result against the oldest expectation
      if (out_valid && !out_stall) begin
        if (expected_hits.size() == 0) begin
          bad_count++;
          $display("%0t: result expected none actual found=%0b match_offset=%0d",
                   $time, found, match_offset);
        end else begin
          want = expected_hits.pop_front();
          if (found !== want.found) begin
            bad_count++;
            $display("%0t: found expected %0b actual %0b", $time, want.found, found);
          end
          if (match_offset !== want.offset) begin
            bad_count++;
            $display("%0t: match_offset expected %0d actual %0d",
                     $time, want.offset, match_offset);
          end
        end
      end
      if (in_valid && !in_stall) scan_byte(data_byte, region_end);
    end
    waiting = expected_hits.size();
  end

endmodule

// ===== dv/tb_wildcard_byte_pattern_scanner.sv =====
module tb_wildcard_byte_pattern_scanner;
  timeunit 1ns;
  timeprecision 1ps;
  import wbps_pkg::*;

  // indexes outside the register map
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_7 = 3'd7;

  localparam int LONG_HOLD      = 300;
  localparam int IDLE_LIMIT     = 3000;
  localparam int SETTLE         = 4;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_ITEMS    = 123;
  localparam int PRESSURE_PHASE = 7;

  logic                      clk        = 1'b0;
  logic                      rst        = 1'b1;
  logic                      cfg_we     = 1'b0;
  logic [CFG_INDEX_W-1:0]    cfg_index  = '0;
  logic [CFG_DATA_W-1:0]     cfg_data   = '0;
  logic                      in_valid   = 1'b0;
  logic                      in_stall;
  logic [7:0]                data_byte  = '0;
  logic                      region_end = 1'b0;
  logic                      out_valid;
  logic                      out_stall  = 1'b0;
  logic                      found;
  logic [MATCH_OFFSET_W-1:0] match_offset;

  int mismatch_count;
  int results_pending;

  // sender and receiver pacing
  logic gaps_on      = 1'b0;
  logic rx_stalls_on = 1'b1;
  logic hold_off_req = 1'b0;
  int   burst_left   = 0;
  int   idle_cycles  = 0;

  // stimulus-side view of the current pattern
  logic [7:0]        pat_mirror [LEN_LIMIT];
  logic [MASK_W-1:0] wild_mirror;
  int                scan_len = 1;

  wildcard_byte_pattern_scanner u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .region_end   (region_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .found        (found),
    .match_offset (match_offset)
  );

  wbps_scan_checker u_scan_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .region_end   (region_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .found        (found),
    .match_offset (match_offset),
    .mismatches   (mismatch_count),
    .pending      (results_pending)
  );

  initial begin : clock_gen
    forever #5 clk = ~clk;
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("wildcard_byte_pattern_scanner verification failed");
      $finish;
    end
  end

  // result side: random stall runs, plus one long hold-off on request
  initial begin : receiver
    int   run_left;
    logic stalling;
    run_left = 0;
    stalling = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        run_left = 0;
      end else begin
        if (run_left == 0) begin
          stalling = ($urandom_range(0, 2) == 0);
          run_left = stalling ? $urandom_range(1, 8) : $urandom_range(1, 24);
        end
        run_left--;
        out_stall <= stalling && rx_stalls_on;
      end
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // program every register, with junk in the unused upper bits
  task automatic apply_config(input logic [CFG_DATA_W-1:0] w0, input logic [CFG_DATA_W-1:0] w1,
                              input logic [CFG_DATA_W-1:0] w2, input logic [CFG_DATA_W-1:0] w3,
                              input logic [MASK_W-1:0] mask,
                              input logic [PATTERN_LENGTH_W-1:0] len_raw);
    logic [CFG_DATA_W-1:0] words [4];
    int                    i;
    words = '{w0, w1, w2, w3};
    write_reg(REG_PATTERN_WORD_0, w0);
    write_reg(REG_PATTERN_WORD_1, w1);
    write_reg(REG_SPARE_6, {$urandom, $urandom});
    write_reg(REG_PATTERN_WORD_2, w2);
    write_reg(REG_PATTERN_WORD_3, w3);
    write_reg(REG_WILDCARD_MASK, {$urandom, mask});
    write_reg(REG_PATTERN_LENGTH, {$urandom, 26'($urandom), len_raw});
    write_reg(REG_SPARE_7, {$urandom, $urandom});
    cfg_we <= 1'b0;
    for (i = 0; i < LEN_LIMIT; i++) pat_mirror[i] = words[i / 8][(i % 8) * 8 +: 8];
    wild_mirror = mask;
    scan_len = (len_raw == '0) ? 1 : ((len_raw > LEN_LIMIT) ? LEN_LIMIT : len_raw);
  endtask

  // offer one byte, with bursts and gaps when enabled
  task automatic send_item(input logic [7:0] value, input logic last);
    logic stalled;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    in_valid   <= 1'b1;
    data_byte  <= value;
    region_end <= last;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
  endtask

  task automatic send_bytes(input logic [7:0] seq [$]);
    int k;
    for (k = 0; k < seq.size(); k++) send_item(seq[k], k == seq.size() - 1);
  endtask

  // pattern copy starts at byte plant_at (may hang off either end)
  task automatic send_region(input int n, input int plant_at, input logic spoil,
                             input logic narrow);
    int         k;
    int         pos;
    int         spoil_pos;
    logic [7:0] value;
    spoil_pos = $urandom_range(0, scan_len - 1);
    for (k = 0; k < n; k++) begin
      pos = k - plant_at;
      if (narrow) value = pat_mirror[$urandom_range(0, scan_len - 1)];
      else value = 8'($urandom);
      if (pos >= 0 && pos < scan_len && !wild_mirror[pos]) begin
        value = pat_mirror[pos];
        if (spoil && pos == spoil_pos) value = value ^ (8'h01 << $urandom_range(0, 7));
      end
      send_item(value, k == n - 1);
    end
  endtask

  task automatic run_regions(input int items, input logic short_regions);
    int done;
    int n;
    int plant;
    int kind;
    done = 0;
    while (done < items) begin
      kind = $urandom_range(0, 9);
      if (short_regions) n = $urandom_range(1, 3);
      else if (kind == 0) n = $urandom_range(1, scan_len);
      else n = scan_len + $urandom_range(0, 24);
      if (kind < 2) begin
        plant = n + 1;
      end else if (kind < 4) begin
        plant = n - scan_len;
      end else if (kind == 4) begin
        plant = n - scan_len + int'($urandom_range(0, scan_len));
      end else begin
        plant = int'($urandom_range(0, n)) - int'($urandom_range(0, scan_len));
      end
      send_region(n, plant, kind == 5 || kind == 6, $urandom_range(0, 3) == 0);
      done += n;
    end
  endtask

  // wait for every expected result, then let the pipeline empty
  task automatic wait_scan_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [CFG_DATA_W-1:0]       w [4];
    logic [MASK_W-1:0]           mask;
    logic [PATTERN_LENGTH_W-1:0] len_raw;
    int                          p;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset pattern is a single zero byte
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b1);
    wait_scan_idle();

    // four-byte pattern with a wildcard in position 2
    apply_config(64'h0000_0000_4400_4241, '0, '0, '0, 32'h0000_0004, 6'd4);
    send_bytes('{8'h41, 8'h42, 8'hFF, 8'h44});
    send_bytes('{8'h44, 8'h41, 8'h42, 8'h00, 8'h44, 8'h41, 8'h42, 8'h01, 8'h44});
    // pattern split across two regions must not match
    send_bytes('{8'h41, 8'h42});
    send_bytes('{8'h00, 8'h44});
    wait_scan_idle();

    // length zero behaves as one
    apply_config(64'h0000_0000_0000_00FF, '0, '0, '0, '0, 6'd0);
    send_bytes('{8'hFF});
    send_bytes('{8'h00, 8'h00, 8'hFF, 8'h00});

    // random phases, extremes of the length and mask first
    for (p = 0; p < RANDOM_PHASES; p++) begin
      wait_scan_idle();
      foreach (w[i]) w[i] = {$urandom, $urandom};
      mask    = $urandom & $urandom;
      len_raw = 6'($urandom_range(2, 12));
      case (p)
        0: begin
          len_raw = 6'd32;
          mask    = '0;
        end
        1: len_raw = 6'd63;
        2: len_raw = 6'd0;
        3: begin
          len_raw = 6'd1;
          mask    = '1;
        end
        4: len_raw = 6'($urandom_range(33, 62));
        5: len_raw = 6'($urandom_range(24, 31));
        default: ;
      endcase
      apply_config(w[0], w[1], w[2], w[3], mask, len_raw);
      gaps_on      = (p % 3 != 2);
      rx_stalls_on = (p % 4 != 3);
      // back results up while the sender keeps pushing short regions
      if (p == PRESSURE_PHASE) begin
        gaps_on      = 1'b0;
        hold_off_req = 1'b1;
      end
      run_regions(PHASE_ITEMS, p == PRESSURE_PHASE);
    end

    wait_scan_idle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("wildcard_byte_pattern_scanner verification clean");
    end else begin
      $display("wildcard_byte_pattern_scanner verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/wbps_pkg.sv
design/wbps_cfg.sv
design/wildcard_byte_pattern_scanner.sv
dv/wbps_scan_checker.sv
dv/tb_wildcard_byte_pattern_scanner.sv
